FILE: rtl/core/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define RBHT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
        else $error("%m: implication check failed");

// Invariant checked at every rising clock edge outside reset.
`define RBHT_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("%m: invariant check failed");

`endif

FILE: rtl/core/rbht_pkg.sv
// ----------------------------------------------------------------------------
// rbht_pkg
// Shared constants and types of the ray versus box hit test core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rbht_pkg;

    localparam int COORD_BITS  = 32;
    localparam int AXES        = 3;
    localparam int FACES       = 2;
    localparam int OTHERS      = AXES - 1;
    localparam int DIFF_BITS   = COORD_BITS + 1;
    localparam int PROD_BITS   = 2 * DIFF_BITS;
    localparam int LANE_STAGES = 3;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [DIFF_BITS-1:0]  diff_t;
    typedef logic signed [PROD_BITS-1:0]  prod_t;

    // One axis of the box and the ray.
    typedef struct packed {
        coord_t lo;
        coord_t hi;
        coord_t pos;
        coord_t dir;
    } axis_t;

endpackage

`default_nettype wire

FILE: rtl/core/rbht_lane.sv
// ----------------------------------------------------------------------------
// rbht_lane
// Face test of one axis: both faces against the two other axes, three stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rbht_lane (
    input  logic           clk,
    input  rbht_pkg::axis_t own,
    input  rbht_pkg::axis_t other [rbht_pkg::OTHERS],
    output logic           hit
);

    // Stage A: face distances and direction folded to positive
    logic                   dirnz_reg;
    rbht_pkg::diff_t        dd_reg;
    rbht_pkg::diff_t        n_reg    [rbht_pkg::FACES];
    rbht_pkg::coord_t       odir_reg [rbht_pkg::OTHERS];
    rbht_pkg::diff_t        olo_reg  [rbht_pkg::OTHERS];
    rbht_pkg::diff_t        ohi_reg  [rbht_pkg::OTHERS];

    logic                   dir_neg;
    rbht_pkg::diff_t        dir_ext;
    rbht_pkg::diff_t        face_diff [rbht_pkg::FACES];
    rbht_pkg::diff_t        n_next    [rbht_pkg::FACES];

    // Stage B: cross products
    logic                   dirnz_b_reg;
    logic [rbht_pkg::FACES-1:0] nok_reg;
    rbht_pkg::prod_t        mid_reg [rbht_pkg::FACES][rbht_pkg::OTHERS];
    rbht_pkg::prod_t        low_reg [rbht_pkg::OTHERS];
    rbht_pkg::prod_t        top_reg [rbht_pkg::OTHERS];

    // Stage C: bounds compare
    logic [rbht_pkg::FACES-1:0] face_in;
    logic                   hit_reg;
    logic                   hit_next;

    always_comb
    begin
        dir_neg = own.dir[rbht_pkg::COORD_BITS-1];
        dir_ext = rbht_pkg::diff_t'(own.dir);
        face_diff[0] = rbht_pkg::diff_t'(own.lo) - rbht_pkg::diff_t'(own.pos);
        face_diff[1] = rbht_pkg::diff_t'(own.hi) - rbht_pkg::diff_t'(own.pos);
        for (int f = 0; f < rbht_pkg::FACES; f++)
        begin
            n_next[f] = dir_neg ? -face_diff[f] : face_diff[f];
        end
    end

    always_ff @(posedge clk)
    begin
        dirnz_reg <= (own.dir != '0);
        dd_reg    <= dir_neg ? -dir_ext : dir_ext;
        for (int f = 0; f < rbht_pkg::FACES; f++)
        begin
            n_reg[f] <= n_next[f];
        end
        for (int j = 0; j < rbht_pkg::OTHERS; j++)
        begin
            odir_reg[j] <= other[j].dir;
            olo_reg[j]  <= rbht_pkg::diff_t'(other[j].lo) - rbht_pkg::diff_t'(other[j].pos);
            ohi_reg[j]  <= rbht_pkg::diff_t'(other[j].hi) - rbht_pkg::diff_t'(other[j].pos);
        end
    end

    always_ff @(posedge clk)
    begin
        dirnz_b_reg <= dirnz_reg;
        for (int f = 0; f < rbht_pkg::FACES; f++)
        begin
            nok_reg[f] <= ~n_reg[f][rbht_pkg::DIFF_BITS-1];
            for (int j = 0; j < rbht_pkg::OTHERS; j++)
            begin
                mid_reg[f][j] <= rbht_pkg::prod_t'(odir_reg[j]) * rbht_pkg::prod_t'(n_reg[f]);
            end
        end
        for (int j = 0; j < rbht_pkg::OTHERS; j++)
        begin
            low_reg[j] <= rbht_pkg::prod_t'(olo_reg[j]) * rbht_pkg::prod_t'(dd_reg);
            top_reg[j] <= rbht_pkg::prod_t'(ohi_reg[j]) * rbht_pkg::prod_t'(dd_reg);
        end
    end

    always_comb
    begin
        for (int f = 0; f < rbht_pkg::FACES; f++)
        begin
            face_in[f] = 1'b1;
            for (int j = 0; j < rbht_pkg::OTHERS; j++)
            begin
                if (!((low_reg[j] <= mid_reg[f][j]) && (mid_reg[f][j] <= top_reg[j])))
                begin
                    face_in[f] = 1'b0;
                end
            end
        end
        hit_next = dirnz_b_reg && |(nok_reg & face_in);
    end

    always_ff @(posedge clk)
    begin
        hit_reg <= hit_next;
    end

    assign hit = hit_reg;

endmodule

`default_nettype wire

FILE: rtl/core/rbht_merge.sv
// ----------------------------------------------------------------------------
// rbht_merge
// Combine the lane results into one registered hit bit with its strobe.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rbht_merge (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      lane_valid,
    input  logic [rbht_pkg::AXES-1:0] lane_hit,
    output logic                      done,
    output logic                      hit
);

    logic done_reg;
    logic hit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= lane_valid;
        end
    end

    // Payload: any lane that found a face point makes a hit
    always_ff @(posedge clk)
    begin
        hit_reg <= |lane_hit;
    end

    assign done = done_reg;
    assign hit  = hit_reg;

endmodule

`default_nettype wire

FILE: rtl/core/ray_box_hit_test_core.sv
// ----------------------------------------------------------------------------
// ray_box_hit_test_core
// Exact ray versus axis-aligned box face test, fully pipelined.
// ----------------------------------------------------------------------------
// A word (box corners, ray origin and direction, signed Q16.16) is taken at
// every rising edge with start high; busy stays low, so a new word may follow
// in every cycle. The hit result is shown with done high for exactly one
// cycle; the receiver cannot stall it and must take it then. The word passes
// the input register, three axis lanes that each run a three-stage pipeline
// (distances, eight cross products, four of 32 x 33 and four of 33 x 33 bits,
// bounds compare), and one merge register. Throughput is one word per cycle,
// since no stage ever holds a word back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ray_box_hit_test_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  rbht_pkg::coord_t box_lower_x,
    input  rbht_pkg::coord_t box_lower_y,
    input  rbht_pkg::coord_t box_lower_z,
    input  rbht_pkg::coord_t box_upper_x,
    input  rbht_pkg::coord_t box_upper_y,
    input  rbht_pkg::coord_t box_upper_z,
    input  rbht_pkg::coord_t ray_pos_x,
    input  rbht_pkg::coord_t ray_pos_y,
    input  rbht_pkg::coord_t ray_pos_z,
    input  rbht_pkg::coord_t ray_dir_x,
    input  rbht_pkg::coord_t ray_dir_y,
    input  rbht_pkg::coord_t ray_dir_z,
    output logic             done,
    output logic             hit
);

    logic                               accept;
    rbht_pkg::axis_t                    axis_next [rbht_pkg::AXES];
    rbht_pkg::axis_t                    axis_reg  [rbht_pkg::AXES];
    logic                               in_valid_reg;
    logic [rbht_pkg::LANE_STAGES-1:0]   lane_valid_reg;
    logic [rbht_pkg::LANE_STAGES-1:0]   lane_valid_next;
    rbht_pkg::axis_t                    lane_other [rbht_pkg::AXES][rbht_pkg::OTHERS];
    logic [rbht_pkg::AXES-1:0]          lane_hit;

    // No stall source anywhere in the pipe: never busy
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Gather the word into one record per axis
    always_comb
    begin
        axis_next[0] = '{lo: box_lower_x, hi: box_upper_x, pos: ray_pos_x, dir: ray_dir_x};
        axis_next[1] = '{lo: box_lower_y, hi: box_upper_y, pos: ray_pos_y, dir: ray_dir_y};
        axis_next[2] = '{lo: box_lower_z, hi: box_upper_z, pos: ray_pos_z, dir: ray_dir_z};
    end

    // Hold the input word; payload has no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int k = 0; k < rbht_pkg::AXES; k++)
            begin
                axis_reg[k] <= axis_next[k];
            end
        end
    end

    // Advance the valid marks alongside the lane stages
    assign lane_valid_next = {lane_valid_reg[rbht_pkg::LANE_STAGES-2:0], in_valid_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            lane_valid_reg <= '0;
        end
        else
        begin
            in_valid_reg   <= accept;
            lane_valid_reg <= lane_valid_next;
        end
    end

    // One lane per axis; each sees its own axis and the other two in turn
    for (genvar a = 0; a < rbht_pkg::AXES; a++)
    begin : g_lane
        for (genvar j = 0; j < rbht_pkg::OTHERS; j++)
        begin : g_other
            assign lane_other[a][j] = axis_reg[(a + j + 1) % rbht_pkg::AXES];
        end

        rbht_lane u_lane (
            .clk   (clk),
            .own   (axis_reg[a]),
            .other (lane_other[a]),
            .hit   (lane_hit[a])
        );
    end

    rbht_merge u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .lane_valid (lane_valid_reg[rbht_pkg::LANE_STAGES-1]),
        .lane_hit   (lane_hit),
        .done       (done),
        .hit        (hit)
    );

endmodule

`default_nettype wire

FILE: rtl/core/rbht_checker.sv
// ----------------------------------------------------------------------------
// rbht_checker
// Port-level checks of the hit test core, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module rbht_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input rbht_pkg::coord_t ray_dir_x,
    input rbht_pkg::coord_t ray_dir_y,
    input rbht_pkg::coord_t ray_dir_z,
    input logic             done,
    input logic             hit
);

    logic took;
    logic no_dir;

    assign took   = rst_n && start && !busy;
    assign no_dir = (ray_dir_x == '0) && (ray_dir_y == '0) && (ray_dir_z == '0);

    `RBHT_ASSERT_ALWAYS(a_never_busy, clk, rst_n, !busy)
    `RBHT_ASSERT_IMP(a_word_gets_result, clk, rst_n, took, ##5 done)
    `RBHT_ASSERT_IMP(a_result_has_word, clk, rst_n, done, $past(took, 5))
    `RBHT_ASSERT_IMP(a_parallel_ray_misses, clk, rst_n, took && no_dir, ##5 !hit)

endmodule

bind ray_box_hit_test_core rbht_checker u_rbht_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .ray_dir_x (ray_dir_x),
    .ray_dir_y (ray_dir_y),
    .ray_dir_z (ray_dir_z),
    .done      (done),
    .hit       (hit)
);

`default_nettype wire
